>>> sv/sprite_page_shift_lcd_streamer_unit_macros.svh
// Assertion macros shared by the sprite streamer modules.
`ifndef SPRITE_PAGE_SHIFT_LCD_STREAMER_UNIT_MACROS_SVH
`define SPRITE_PAGE_SHIFT_LCD_STREAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define SPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sps assertion failed");

// Next-cycle implication, checked out of reset.
`define SPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sps assertion failed");

`else

`define SPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/sps_pkg.sv
// Types, codes and helper functions of the sprite streamer.
`timescale 1ns / 1ps
package sps_pkg;

    // input item kinds
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_COLUMN = 1'b1;

    // LCD command bytes of the address header
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [7:0] CMD_PAGE     = 8'hB0;

    // column item after classification, waiting for its store read
    typedef struct packed {
        logic       hdr;
        logic [2:0] col_hi;
        logic [3:0] col_lo;
        logic [7:0] page_byte;
        logic [7:0] cur_lo;
        logic [7:0] cur_hi;
        logic [2:0] off;
        logic       use_prev;
        logic       last;
    } sps_cmd_t;

    // queue entry: one column, optional header plus shifted pair
    typedef struct packed {
        logic       hdr;
        logic [2:0] col_hi;
        logic [3:0] col_lo;
        logic [7:0] page_byte;
        logic [7:0] data_lo;
        logic [7:0] data_hi;
        logic       last;
    } sps_entry_t;

    // (prev >> (8-off)) | (cur << off), off = 0 gives cur
    function automatic logic [7:0] shift_pair(input logic [7:0] prev,
                                              input logic [7:0] cur,
                                              input logic [2:0] off);
        logic [15:0] joined;
        joined = {cur, prev} << off;
        return joined[15:8];
    endfunction

endpackage

>>> sv/sps_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
module sps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word when the same address is written
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/sps_front.sv
// Front end: sprite state, column classification and previous-page store.
`timescale 1ns / 1ps
`include "sprite_page_shift_lcd_streamer_unit_macros.svh"
module sps_front #(
    parameter int MAX_WIDTH = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    // bank register
    input  logic                cfg_valid,
    input  logic [4:0]          cfg_data,
    // input items
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [6:0]          s_x_pos,
    input  logic [5:0]          s_y_pos,
    input  logic [7:0]          s_width,
    input  logic [6:0]          s_height,
    input  logic [7:0]          s_plane_low,
    input  logic [7:0]          s_plane_high,
    // to queue
    output logic                q_push,
    output sps_pkg::sps_entry_t q_entry,
    input  logic                q_ready
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [4:0]        bank_reg;
    logic [6:0]        start_col_reg, start_col_next;
    logic [2:0]        off_reg, off_next;
    logic [7:0]        width_reg, width_next;
    logic [7:0]        col_cnt_reg, col_cnt_next;
    logic [4:0]        page_now_reg, page_now_next;
    logic [4:0]        page_end_reg, page_end_next;
    logic              first_page_reg, first_page_next;
    logic              s1_valid_reg, s1_valid_next;
    sps_pkg::sps_cmd_t s1_cmd_reg, s1_cmd_next;

    logic              accept;
    logic              active;
    logic              in_range;
    logic              page_done;
    logic              col_take;
    logic [7:0]        end_sum;
    logic [15:0]       rd_word;
    logic [7:0]        prev_lo;
    logic [7:0]        prev_hi;

    assign s_ready   = !s1_valid_reg || q_ready;
    assign accept    = s_valid && s_ready;
    assign active    = page_now_reg < page_end_reg;
    assign in_range  = {1'b0, col_cnt_reg} < 9'(MAX_WIDTH);
    assign page_done = col_cnt_reg == (width_reg - 8'd1);
    assign col_take  = accept && (s_kind == sps_pkg::KIND_COLUMN) && active;
    assign end_sum   = 8'(s_y_pos) + 8'(s_height) + 8'd7;

    // sprite state and classification
    always_comb begin
        start_col_next  = start_col_reg;
        off_next        = off_reg;
        width_next      = width_reg;
        col_cnt_next    = col_cnt_reg;
        page_now_next   = page_now_reg;
        page_end_next   = page_end_reg;
        first_page_next = first_page_reg;
        s1_valid_next   = s1_valid_reg && !q_ready;
        s1_cmd_next     = s1_cmd_reg;
        if (accept && (s_kind == sps_pkg::KIND_START)) begin
            start_col_next  = s_x_pos;
            off_next        = s_y_pos[2:0];
            width_next      = s_width;
            col_cnt_next    = 8'd0;
            page_now_next   = {2'b00, s_y_pos[5:3]};
            page_end_next   = end_sum[7:3];
            first_page_next = 1'b1;
        end else if (col_take) begin
            s1_valid_next         = 1'b1;
            s1_cmd_next.hdr       = col_cnt_reg == 8'd0;
            s1_cmd_next.col_hi    = start_col_reg[6:4];
            s1_cmd_next.col_lo    = start_col_reg[3:0];
            s1_cmd_next.page_byte = 8'(page_now_reg) + {bank_reg, 3'b000};
            s1_cmd_next.cur_lo    = s_plane_low;
            s1_cmd_next.cur_hi    = s_plane_high;
            s1_cmd_next.off       = off_reg;
            s1_cmd_next.use_prev  = !first_page_reg && in_range;
            s1_cmd_next.last      = page_done
                                    && ((6'(page_now_reg) + 6'd1) == 6'(page_end_reg));
            if (page_done) begin
                col_cnt_next    = 8'd0;
                page_now_next   = page_now_reg + 5'd1;
                first_page_next = 1'b0;
            end else begin
                col_cnt_next = col_cnt_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg       <= 5'd0;
            start_col_reg  <= 7'd0;
            off_reg        <= 3'd0;
            width_reg      <= 8'd0;
            col_cnt_reg    <= 8'd0;
            page_now_reg   <= 5'd0;
            page_end_reg   <= 5'd0;
            first_page_reg <= 1'b1;
            s1_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                bank_reg <= cfg_data;
            end
            start_col_reg  <= start_col_next;
            off_reg        <= off_next;
            width_reg      <= width_next;
            col_cnt_reg    <= col_cnt_next;
            page_now_reg   <= page_now_next;
            page_end_reg   <= page_end_next;
            first_page_reg <= first_page_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_cmd_reg <= s1_cmd_next;
    end

    // previous-page store: read old word and write the new one in the same cycle
    sps_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (col_take && in_range),
        .wr_addr (col_cnt_reg[AW-1:0]),
        .wr_data ({s_plane_high, s_plane_low}),
        .rd_en   (col_take),
        .rd_addr (col_cnt_reg[AW-1:0]),
        .rd_data (rd_word)
    );

    // shift with the previous page and hand over to the queue
    assign prev_lo = s1_cmd_reg.use_prev ? rd_word[7:0]  : 8'd0;
    assign prev_hi = s1_cmd_reg.use_prev ? rd_word[15:8] : 8'd0;

    assign q_push            = s1_valid_reg && q_ready;
    assign q_entry.hdr       = s1_cmd_reg.hdr;
    assign q_entry.col_hi    = s1_cmd_reg.col_hi;
    assign q_entry.col_lo    = s1_cmd_reg.col_lo;
    assign q_entry.page_byte = s1_cmd_reg.page_byte;
    assign q_entry.data_lo   = sps_pkg::shift_pair(prev_lo, s1_cmd_reg.cur_lo, s1_cmd_reg.off);
    assign q_entry.data_hi   = sps_pkg::shift_pair(prev_hi, s1_cmd_reg.cur_hi, s1_cmd_reg.off);
    assign q_entry.last      = s1_cmd_reg.last;

    // a stalled column waits with its previous-page bytes intact
    `SPS_ASSERT_NEXT(a_s1_hold, aclk, aresetn, s1_valid_reg && !q_ready,
                     s1_valid_reg && $stable(prev_lo) && $stable(prev_hi) && $stable(s1_cmd_reg))
    // nothing is accepted over a stalled column
    `SPS_ASSERT_NOW(a_no_overrun, aclk, aresetn, s1_valid_reg && !q_ready, !accept)

endmodule

>>> sv/sps_queue.sv
// Two-entry queue between front and back end.
`timescale 1ns / 1ps
`include "sprite_page_shift_lcd_streamer_unit_macros.svh"
module sps_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sps_pkg::sps_entry_t push_entry,
    output logic                ready,
    input  logic                pop,
    output logic                valid,
    output sps_pkg::sps_entry_t head
);

    sps_pkg::sps_entry_t slot_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;

    assign ready = count_reg != 2'd2;
    assign valid = count_reg != 2'd0;
    assign head  = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers stay consistent with the fill count
    `SPS_ASSERT_NOW(a_ptr_fill, aclk, aresetn, count_reg == 2'd0 || count_reg == 2'd2,
                    wr_ptr_reg == rd_ptr_reg)
    `SPS_ASSERT_NOW(a_no_overflow, aclk, aresetn, 1'b1,
                    !(push && !ready) && !(pop && !valid))

endmodule

>>> sv/sps_back.sv
// Back end: turns queue entries into header and data items on the output.
`timescale 1ns / 1ps
`include "sprite_page_shift_lcd_streamer_unit_macros.svh"
module sps_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  sps_pkg::sps_entry_t q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_is_header,
    output logic [7:0]          m_byte_one,
    output logic [7:0]          m_byte_two,
    output logic [7:0]          m_byte_three,
    output logic                m_last
);

    logic       m_valid_reg, m_valid_next;
    logic       hdr_sent_reg, hdr_sent_next;
    logic       is_header_reg, is_header_next;
    logic [7:0] byte_one_reg, byte_one_next;
    logic [7:0] byte_two_reg, byte_two_next;
    logic [7:0] byte_three_reg, byte_three_next;
    logic       last_reg, last_next;
    logic       load;
    logic       send_hdr;

    assign load     = (!m_valid_reg || m_ready) && q_valid;
    assign send_hdr = q_head.hdr && !hdr_sent_reg;
    assign q_pop    = load && !send_hdr;

    // output register: header first when the column opens a page
    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        hdr_sent_next   = hdr_sent_reg;
        is_header_next  = is_header_reg;
        byte_one_next   = byte_one_reg;
        byte_two_next   = byte_two_reg;
        byte_three_next = byte_three_reg;
        last_next       = last_reg;
        if (load) begin
            m_valid_next = 1'b1;
            if (send_hdr) begin
                hdr_sent_next   = 1'b1;
                is_header_next  = 1'b1;
                byte_one_next   = sps_pkg::CMD_COL_HIGH | {5'd0, q_head.col_hi};
                byte_two_next   = {4'd0, q_head.col_lo};
                byte_three_next = sps_pkg::CMD_PAGE | q_head.page_byte;
                last_next       = 1'b0;
            end else begin
                hdr_sent_next   = 1'b0;
                is_header_next  = 1'b0;
                byte_one_next   = q_head.data_lo;
                byte_two_next   = q_head.data_hi;
                byte_three_next = 8'd0;
                last_next       = q_head.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            hdr_sent_reg <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            hdr_sent_reg <= hdr_sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_header_reg  <= is_header_next;
        byte_one_reg   <= byte_one_next;
        byte_two_reg   <= byte_two_next;
        byte_three_reg <= byte_three_next;
        last_reg       <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_is_header  = is_header_reg;
    assign m_byte_one   = byte_one_reg;
    assign m_byte_two   = byte_two_reg;
    assign m_byte_three = byte_three_reg;
    assign m_last       = last_reg;

    // a header taken is followed straight away by its data pair
    `SPS_ASSERT_NEXT(a_hdr_then_data, aclk, aresetn, m_valid_reg && m_ready && is_header_reg,
                     m_valid_reg && !is_header_reg)
    // while a header is out, its column entry stays at the queue head
    `SPS_ASSERT_NOW(a_hdr_holds_entry, aclk, aresetn, hdr_sent_reg, q_valid && q_head.hdr)

endmodule

>>> sv/sprite_page_shift_lcd_streamer_unit.sv
// Top level of the page-mode LCD sprite streamer with vertical shift.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser kind; tdata sprite or column
//  m_       | out       | m_tvalid/m_tready  | tuser is_header; tlast; tdata 3 bytes
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_data page_bank
//
// One input item is taken per cycle while the output keeps up; a column that
// opens a page yields two output items, header then data, others one.
// A column item passes the store read, the queue and the output register
// before its first output item; the single-port-write line store
// is read and written in the acceptance cycle.
// aresetn is synchronous; the line store is not cleared, the first page
// never uses what it reads. A stalled output backs up through a two-entry queue.
`timescale 1ns / 1ps
module sprite_page_shift_lcd_streamer_unit #(
    parameter int MAX_WIDTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_pos[6:0], y_pos[12:7], width[20:13],
                                   // height[27:21], plane_low[35:28],
                                   // plane_high[43:36], zero[47:44]
    input  logic        s_tuser,   // kind
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // byte_one[7:0], byte_two[15:8], byte_three[23:16]
    output logic        m_tuser,   // is_header
    output logic        m_tlast    // last
);

    sps_pkg::sps_entry_t q_entry;
    sps_pkg::sps_entry_t q_head;
    logic                q_push;
    logic                q_ready;
    logic                q_pop;
    logic                q_valid;

    assign cfg_ready = 1'b1;

    sps_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_kind       (s_tuser),
        .s_x_pos      (s_tdata[6:0]),
        .s_y_pos      (s_tdata[12:7]),
        .s_width      (s_tdata[20:13]),
        .s_height     (s_tdata[27:21]),
        .s_plane_low  (s_tdata[35:28]),
        .s_plane_high (s_tdata[43:36]),
        .q_push       (q_push),
        .q_entry      (q_entry),
        .q_ready      (q_ready)
    );

    sps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .ready      (q_ready),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    sps_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_is_header  (m_tuser),
        .m_byte_one   (m_tdata[7:0]),
        .m_byte_two   (m_tdata[15:8]),
        .m_byte_three (m_tdata[23:16]),
        .m_last       (m_tlast)
    );

endmodule

>>> bench/tb_sprite_page_shift_lcd_streamer_unit.sv
// Self-checking testbench for the page-mode LCD sprite streamer with vertical shift.
`timescale 1ns / 1ps
module tb_sprite_page_shift_lcd_streamer_unit;

    localparam int STORE_DEPTH    = 128;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;

    // one result item as the LCD sees it
    typedef struct {
        logic       is_header;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       last;
    } lcd_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = 5'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = 48'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // shadow copy of the block state
    logic [15:0] prev_page_mem [0:STORE_DEPTH-1];
    logic [6:0]  start_col = 7'd0;
    logic [2:0]  row_off = 3'd0;
    logic [7:0]  cols_per_page = 8'd0;
    logic [7:0]  col_idx = 8'd0;
    logic [4:0]  cur_page = 5'd0;
    logic [4:0]  end_page = 5'd0;
    logic        first_pg = 1'b1;
    logic [4:0]  bank_reg = 5'd0;

    lcd_word_t lcd_words_due[$];
    int error_count = 0;
    int sent_items = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;
    int hold_len = 0;
    int hold_seq = 0;

    sprite_page_shift_lcd_streamer_unit #(
        .MAX_WIDTH(STORE_DEPTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),   // x_pos, y_pos, width, height, plane_low, plane_high, zero
        .s_tuser(s_tuser),   // kind
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),   // byte_one, byte_two, byte_three
        .m_tuser(m_tuser),   // is_header
        .m_tlast(m_tlast)    // last
    );

    always #4 aclk = ~aclk;

    // (prev >> (8-off)) | (cur << off); off 0 passes cur through
    function automatic logic [7:0] merge_rows(input logic [7:0] prev, input logic [7:0] cur,
                                              input logic [2:0] off);
        logic [7:0] merged;
        if (off == 3'd0)
            return cur;
        merged = (cur << off) | (prev >> (4'd8 - {1'b0, off}));
        return merged;
    endfunction

    // advance the shadow state by one item and queue the LCD words it produces
    function automatic int predict_lcd_words(input logic kind, input logic [6:0] x,
                                             input logic [5:0] y, input logic [7:0] w,
                                             input logic [6:0] h, input logic [7:0] lo,
                                             input logic [7:0] hi);
        int n;
        int pe;
        int pg;
        logic [15:0] prev;
        logic page_done;
        lcd_word_t word;
        n = 0;
        if (kind == sps_pkg::KIND_START) begin
            start_col     = x;
            row_off       = y[2:0];
            cols_per_page = w;
            col_idx       = 8'd0;
            cur_page      = {2'b00, y[5:3]};
            pe            = (int'(y) + int'(h) + 7) >> 3;
            end_page      = pe[4:0];
            first_pg      = 1'b1;
        end else if (cur_page < end_page) begin
            page_done = (col_idx == cols_per_page - 8'd1);
            // address header at the first column of each page
            if (col_idx == 8'd0) begin
                pg = (int'(cur_page) + int'(bank_reg) * 8) & 255;
                word.is_header = 1'b1;
                word.b1 = sps_pkg::CMD_COL_HIGH | {5'd0, start_col[6:4]};
                word.b2 = {4'd0, start_col[3:0]};
                word.b3 = sps_pkg::CMD_PAGE | pg[7:0];
                word.last = 1'b0;
                lcd_words_due.push_back(word);
                n++;
            end
            prev = 16'h0000;
            if (!first_pg && col_idx < STORE_DEPTH)
                prev = prev_page_mem[col_idx[STORE_AW-1:0]];
            word.is_header = 1'b0;
            word.b1 = merge_rows(prev[7:0], lo, row_off);
            word.b2 = merge_rows(prev[15:8], hi, row_off);
            word.b3 = 8'h00;
            word.last = page_done && (int'(cur_page) + 1 == int'(end_page));
            lcd_words_due.push_back(word);
            n++;
            if (col_idx < STORE_DEPTH)
                prev_page_mem[col_idx[STORE_AW-1:0]] = {hi, lo};
            if (page_done) begin
                col_idx  = 8'd0;
                cur_page = cur_page + 5'd1;
                first_pg = 1'b0;
            end else begin
                col_idx = col_idx + 8'd1;
            end
        end
        return n;
    endfunction

    // columns the host sends for a sprite, padding page included
    function automatic int sprite_columns(input int y, input int w, input int h);
        int pn;
        int pe;
        pn = y >> 3;
        pe = ((y + h + 7) >> 3) & 31;
        if (pe <= pn)
            return 0;
        return (pe - pn) * ((w == 0) ? 256 : w);
    endfunction

    // offer one item, with random gaps ahead of it, and predict on acceptance
    task automatic send_item(input logic kind, input logic [6:0] x, input logic [5:0] y,
                             input logic [7:0] w, input logic [6:0] h,
                             input logic [7:0] lo, input logic [7:0] hi);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'h0, hi, lo, h, w, y, x};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        void'(predict_lcd_words(kind, x, y, w, h, lo, hi));
        sent_items++;
    endtask

    task automatic send_start(input int x, input int y, input int w, input int h);
        send_item(sps_pkg::KIND_START, 7'(x), 6'(y), 8'(w), 7'(h),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_column(input logic [7:0] lo, input logic [7:0] hi);
        send_item(sps_pkg::KIND_COLUMN, 7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)), lo, hi);
    endtask

    task automatic send_columns(input int count);
        for (int i = 0; i < count; i++)
            send_column(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (lcd_words_due.size() != 0)
            @(posedge aclk);
    endtask

    // idle the input and let any work on result-free items finish
    task automatic settle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bank(input logic [4:0] bank);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= bank;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        bank_reg = bank;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle_mix(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // columns before any start are dropped
    task automatic test_idle_columns();
        send_columns(2);
    endtask

    task automatic test_corner_sprites();
        write_bank(5'd31);
        // last column and row, offset 7, page byte wraps past 0xFF
        send_start(127, 63, 2, 8);
        send_column(8'hFF, 8'hFF);
        send_column(8'h00, 8'h00);
        send_column(8'hFF, 8'h00);
        send_column(8'h00, 8'hFF);
        send_column(8'hA5, 8'h5A);          // sprite done, ignored
        // aligned row: bytes go through unshifted
        send_start(0, 0, 3, 8);
        send_column(8'h80, 8'h01);
        send_column(8'hFF, 8'hFF);
        send_column(8'h00, 8'h00);
        // zero height on an aligned row draws nothing
        send_start(85, 8, 1, 0);
        send_column(8'h3C, 8'hC3);
        // height not a multiple of eight
        send_start(42, 2, 2, 12);
        send_columns(4);
        // new start in the middle of a sprite
        send_start(10, 20, 2, 8);
        send_columns(1);
        send_start(11, 0, 1, 8);
        send_columns(1);
        write_bank(5'd0);
    endtask

    task automatic test_wide_pages();
        // width zero: 256 columns per page; on the second page columns past
        // the line store read zero, then the next start cuts the sprite short
        send_start(64, 5, 0, 8);
        send_columns(256 + STORE_DEPTH + 1);
    endtask

    task automatic test_backpressure();
        settle();
        // receiver stalls long while columns keep coming
        hold_len <= HOLD_CYCLES;
        hold_seq <= hold_seq + 1;
        send_start(33, 0, 8, 8);
        send_columns(8);
        // sender stops mid-sprite until every word is out
        send_start(70, 3, 4, 8);
        send_columns(3);
        wait_results_done();
        send_columns(sprite_columns(3, 4, 8) - 3);
    endtask

    task automatic pick_sprite(output int x, output int y, output int w, output int h);
        int shape;
        shape = $urandom_range(0, 99);
        x = $urandom_range(0, 127);
        y = $urandom_range(0, 63);
        if (shape < 70) begin
            w = $urandom_range(1, 12);
            h = 8 * $urandom_range(1, 3);
        end else if (shape < 85) begin
            w = $urandom_range(1, 3);
            h = $urandom_range(0, 127);
        end else if (shape < 95) begin
            w = $urandom_range(13, 40);
            h = $urandom_range(1, 16);
        end else begin
            w = $urandom_range(64, 127);
            y = 8 * $urandom_range(0, 7);
            h = 8;
        end
    endtask

    task automatic test_random_sprites(input int target);
        int first_count;
        int pick;
        int cols;
        int x, y, w, h;
        first_count = sent_items;
        while (sent_items - first_count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
                pick_sprite(x, y, w, h);
                send_start(x, y, w, h);
                cols = sprite_columns(y, w, h);
                // cut short, the next start takes over
                if (pick >= 75)
                    cols = $urandom_range(0, cols);
                // keep this run to its share of items
                if (cols > target - (sent_items - first_count))
                    cols = target - (sent_items - first_count);
                send_columns(cols);
            end else begin
                repeat ($urandom_range(1, 3))
                    send_item(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                              6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
            end
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin : drive_ready
        int hold_left;
        int hold_seen;
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // compare each accepted word with the oldest prediction
    always @(posedge aclk) begin : check_words
        lcd_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (lcd_words_due.size() == 0) begin
                $error("unexpected result: tuser %0b tdata %06h tlast %0b",
                       m_tuser, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = lcd_words_due.pop_front();
                if (m_tuser !== want.is_header) begin
                    $error("is_header: expected %0b, got %0b", want.is_header, m_tuser);
                    error_count++;
                end
                if (m_tdata[7:0] !== want.b1) begin
                    $error("byte_one: expected %02h, got %02h", want.b1, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[15:8] !== want.b2) begin
                    $error("byte_two: expected %02h, got %02h", want.b2, m_tdata[15:8]);
                    error_count++;
                end
                if (m_tdata[23:16] !== want.b3) begin
                    $error("byte_three: expected %02h, got %02h", want.b3, m_tdata[23:16]);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("sprite_page_shift_lcd_streamer_unit test failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle_mix(17, 63);
        test_idle_columns();
        test_corner_sprites();
        test_wide_pages();
        test_backpressure();
        test_random_sprites(12);

        write_bank(5'($urandom_range(1, 30)));
        set_idle_mix(63, 17);
        test_random_sprites(12);

        write_bank(5'd31);
        set_idle_mix(0, 0);
        test_random_sprites(12);

        settle();
        if (error_count == 0)
            $display("sprite_page_shift_lcd_streamer_unit test passed");
        else
            $display("sprite_page_shift_lcd_streamer_unit test failed");
        $finish;
    end

endmodule
